[rtl/core/cpt_pkg.sv]
// Shared types for the closest-point-on-triangle pipeline.
`default_nettype none

package cpt_pkg;

    typedef enum logic [2:0]
    {
        RGN_A  = 3'd0,
        RGN_B  = 3'd1,
        RGN_C  = 3'd2,
        RGN_AB = 3'd3,
        RGN_AC = 3'd4,
        RGN_BC = 3'd5,
        RGN_IN = 3'd6
    } region_t;

endpackage

`default_nettype wire

[rtl/core/closest_point_on_triangle_top.sv]
// Closest point on a triangle: top level, pipeline stages and output register.
// One point/triangle transaction enters per clock and one result leaves per
// clock while the output is not stalled. Eight stages form the edge vectors,
// dot products, their cross products (two-stage multipliers) and the region
// pick; the two ratio dividers produce one quotient bit per stage (FRAC_BITS
// stages); three stages blend the point.
// An output stall while a result is waiting freezes the whole pipeline, so nothing is dropped.
`default_nettype none

module closest_point_on_triangle_top #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    input  logic signed [COORD_WIDTH-1:0] vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] vert_c_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z,
    output logic [FRAC_BITS:0]            weight_a,
    output logic [FRAC_BITS:0]            weight_b,
    output logic [FRAC_BITS:0]            weight_c,
    output logic [2:0]                    region
);
    import cpt_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int DTW = PW + 2;
    localparam int EW  = DTW + 2;
    localparam int VPW = 2 * DTW;
    localparam int VW  = VPW + 1;
    localparam int NW  = VW + 2;
    localparam int PMW = F + 2 + DW;
    localparam int SW  = W + F + 5;
    localparam int HW  = SW - F;
    localparam int NST = F + 11;
    localparam logic [F:0]    WONE = {1'b1, {F{1'b0}}};
    localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

    typedef struct packed {
        logic [2:0][W-1:0]  a;
        logic [2:0][W-1:0]  b;
        logic [2:0][W-1:0]  c;
        logic [2:0][DW-1:0] ab;
        logic [2:0][DW-1:0] ac;
        logic [2:0][DW-1:0] bc;
    } geo_t;

    typedef struct packed {
        logic          fa;
        logic          fb;
        logic          fc;
        logic          fab;
        logic          fac;
        logic          fbc;
        logic [EW-1:0] n_ab;
        logic [EW-1:0] n_ac;
        logic [EW-1:0] n_bc;
        logic [EW-1:0] dn_ab;
        logic [EW-1:0] dn_ac;
        logic [EW-1:0] dn_bc;
    } edge_t;

    typedef struct packed {
        logic [2:0][W-1:0]  base;
        logic [2:0][DW-1:0] e1;
        logic [2:0][DW-1:0] e2;
    } blend_t;

    typedef struct packed {
        region_t rg;
        logic    z1;
        logic    z2;
        logic    s1;
        logic    s2;
        blend_t  bl;
    } side_t;

    logic           en;
    logic           acc;
    logic [NST-1:0] vld_reg;

    assign en        = !(vld_reg[NST-1] && out_stall);
    assign acc       = in_valid && en;
    assign in_stall  = !en;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], acc};
        end
    end

    // stage 1: edge and offset vectors
    logic signed [W-1:0]  pin [3];
    logic signed [W-1:0]  ain [3];
    logic signed [W-1:0]  bin [3];
    logic signed [W-1:0]  cin [3];
    geo_t                 geo_next;
    geo_t                 geo_reg [7];
    logic signed [DW-1:0] ap_reg [3];
    logic signed [DW-1:0] bp_reg [3];
    logic signed [DW-1:0] cp_reg [3];

    assign pin[0] = query_x;
    assign pin[1] = query_y;
    assign pin[2] = query_z;
    assign ain[0] = vert_a_x;
    assign ain[1] = vert_a_y;
    assign ain[2] = vert_a_z;
    assign bin[0] = vert_b_x;
    assign bin[1] = vert_b_y;
    assign bin[2] = vert_b_z;
    assign cin[0] = vert_c_x;
    assign cin[1] = vert_c_y;
    assign cin[2] = vert_c_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_next.a[k]  = ain[k];
            geo_next.b[k]  = bin[k];
            geo_next.c[k]  = cin[k];
            geo_next.ab[k] = DW'(bin[k]) - DW'(ain[k]);
            geo_next.ac[k] = DW'(cin[k]) - DW'(ain[k]);
            geo_next.bc[k] = DW'(cin[k]) - DW'(bin[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= geo_next;
            for (int i = 1; i < 7; i++)
            begin
                geo_reg[i] <= geo_reg[i-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                ap_reg[k] <= DW'(pin[k]) - DW'(ain[k]);
                bp_reg[k] <= DW'(pin[k]) - DW'(bin[k]);
                cp_reg[k] <= DW'(pin[k]) - DW'(cin[k]);
            end
        end
    end

    // stages 2-3: dot products d1..d6
    logic signed [PW-1:0]  pr_reg [6][3];
    logic signed [DTW-1:0] dd_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pr_reg[0][k] <= $signed(geo_reg[0].ab[k]) * ap_reg[k];
                pr_reg[1][k] <= $signed(geo_reg[0].ac[k]) * ap_reg[k];
                pr_reg[2][k] <= $signed(geo_reg[0].ab[k]) * bp_reg[k];
                pr_reg[3][k] <= $signed(geo_reg[0].ac[k]) * bp_reg[k];
                pr_reg[4][k] <= $signed(geo_reg[0].ab[k]) * cp_reg[k];
                pr_reg[5][k] <= $signed(geo_reg[0].ac[k]) * cp_reg[k];
            end
            for (int j = 0; j < 6; j++)
            begin
                dd_reg[j] <= DTW'(pr_reg[j][0]) + DTW'(pr_reg[j][1]) + DTW'(pr_reg[j][2]);
            end
        end
    end

    // stages 4-5: cross terms in the multipliers, region tests on the side
    logic signed [VPW-1:0] mp [6];
    logic signed [EW-1:0]  x43;
    logic signed [EW-1:0]  x56;
    edge_t                 ed_next;
    edge_t                 ed_reg [3];

    cpt_mul #(.N(DTW)) u_mul0 (.clk(clk), .en(en), .a(dd_reg[0]), .b(dd_reg[3]), .p(mp[0]));
    cpt_mul #(.N(DTW)) u_mul1 (.clk(clk), .en(en), .a(dd_reg[2]), .b(dd_reg[1]), .p(mp[1]));
    cpt_mul #(.N(DTW)) u_mul2 (.clk(clk), .en(en), .a(dd_reg[4]), .b(dd_reg[1]), .p(mp[2]));
    cpt_mul #(.N(DTW)) u_mul3 (.clk(clk), .en(en), .a(dd_reg[0]), .b(dd_reg[5]), .p(mp[3]));
    cpt_mul #(.N(DTW)) u_mul4 (.clk(clk), .en(en), .a(dd_reg[2]), .b(dd_reg[5]), .p(mp[4]));
    cpt_mul #(.N(DTW)) u_mul5 (.clk(clk), .en(en), .a(dd_reg[4]), .b(dd_reg[3]), .p(mp[5]));

    always_comb
    begin
        x43           = EW'(dd_reg[3]) - EW'(dd_reg[2]);
        x56           = EW'(dd_reg[4]) - EW'(dd_reg[5]);
        ed_next.fa    = (dd_reg[0] <= 0) && (dd_reg[1] <= 0);
        ed_next.fb    = (dd_reg[2] >= 0) && (dd_reg[3] <= dd_reg[2]);
        ed_next.fc    = (dd_reg[5] >= 0) && (dd_reg[4] <= dd_reg[5]);
        ed_next.fab   = (dd_reg[0] >= 0) && (dd_reg[2] <= 0);
        ed_next.fac   = (dd_reg[1] >= 0) && (dd_reg[5] <= 0);
        ed_next.fbc   = (x43 >= 0) && (x56 >= 0);
        ed_next.n_ab  = EW'(dd_reg[0]);
        ed_next.n_ac  = EW'(dd_reg[1]);
        ed_next.n_bc  = x43;
        ed_next.dn_ab = EW'(dd_reg[0]) - EW'(dd_reg[2]);
        ed_next.dn_ac = EW'(dd_reg[1]) - EW'(dd_reg[5]);
        ed_next.dn_bc = x43 + x56;
    end

    // stage 6: va, vb, vc
    logic signed [VW-1:0] va_reg;
    logic signed [VW-1:0] vb_reg;
    logic signed [VW-1:0] vc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ed_reg[0] <= ed_next;
            ed_reg[1] <= ed_reg[0];
            ed_reg[2] <= ed_reg[1];
            va_reg    <= VW'(mp[4]) - VW'(mp[5]);
            vb_reg    <= VW'(mp[2]) - VW'(mp[3]);
            vc_reg    <= VW'(mp[0]) - VW'(mp[1]);
        end
    end

    // stage 7: region pick and ratio operands
    region_t              rg7_next;
    logic signed [NW-1:0] n1_7_next;
    logic signed [NW-1:0] dn7_next;
    region_t              rg7_reg;
    logic signed [NW-1:0] n1_7_reg;
    logic signed [NW-1:0] n2_7_reg;
    logic signed [NW-1:0] dn7_reg;

    always_comb
    begin
        if (ed_reg[2].fa)
            rg7_next = RGN_A;
        else if (ed_reg[2].fb)
            rg7_next = RGN_B;
        else if (ed_reg[2].fc)
            rg7_next = RGN_C;
        else if ((vc_reg <= 0) && ed_reg[2].fab)
            rg7_next = RGN_AB;
        else if ((vb_reg <= 0) && ed_reg[2].fac)
            rg7_next = RGN_AC;
        else if ((va_reg <= 0) && ed_reg[2].fbc)
            rg7_next = RGN_BC;
        else
            rg7_next = RGN_IN;

        case (rg7_next)
            RGN_AB:
            begin
                n1_7_next = NW'($signed(ed_reg[2].n_ab));
                dn7_next  = NW'($signed(ed_reg[2].dn_ab));
            end
            RGN_AC:
            begin
                n1_7_next = NW'($signed(ed_reg[2].n_ac));
                dn7_next  = NW'($signed(ed_reg[2].dn_ac));
            end
            RGN_BC:
            begin
                n1_7_next = NW'($signed(ed_reg[2].n_bc));
                dn7_next  = NW'($signed(ed_reg[2].dn_bc));
            end
            default:
            begin
                n1_7_next = NW'(vb_reg);
                dn7_next  = NW'(va_reg) + NW'(vb_reg) + NW'(vc_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rg7_reg  <= rg7_next;
            n1_7_reg <= n1_7_next;
            n2_7_reg <= NW'(vc_reg);
            dn7_reg  <= dn7_next;
        end
    end

    // stage 8: degenerate check, magnitudes, blend operands
    region_t    rg8_next;
    blend_t     bl8_next;
    region_t    rg8_reg;
    blend_t     bl8_reg;
    logic       z1_8_reg;
    logic       z2_8_reg;
    logic [NW-1:0] m1_8_reg;
    logic [NW-1:0] m2_8_reg;
    logic [NW-1:0] md_8_reg;

    always_comb
    begin
        if ((rg7_reg >= RGN_AB) && (dn7_reg == 0))
            rg8_next = RGN_A;
        else
            rg8_next = rg7_reg;

        bl8_next.base = geo_reg[6].a;
        bl8_next.e1   = '0;
        bl8_next.e2   = '0;
        case (rg8_next)
            RGN_B:
            begin
                bl8_next.base = geo_reg[6].b;
            end
            RGN_C:
            begin
                bl8_next.base = geo_reg[6].c;
            end
            RGN_AB:
            begin
                bl8_next.e1 = geo_reg[6].ab;
            end
            RGN_AC:
            begin
                bl8_next.e1 = geo_reg[6].ac;
            end
            RGN_BC:
            begin
                bl8_next.base = geo_reg[6].b;
                bl8_next.e1   = geo_reg[6].bc;
            end
            RGN_IN:
            begin
                bl8_next.e1 = geo_reg[6].ab;
                bl8_next.e2 = geo_reg[6].ac;
            end
            default:
            begin
                bl8_next.base = geo_reg[6].a;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rg8_reg  <= rg8_next;
            bl8_reg  <= bl8_next;
            z1_8_reg <= (n1_7_reg == 0) || (n1_7_reg[NW-1] != dn7_reg[NW-1]);
            z2_8_reg <= (n2_7_reg == 0) || (n2_7_reg[NW-1] != dn7_reg[NW-1]);
            m1_8_reg <= n1_7_reg[NW-1] ? -n1_7_reg : n1_7_reg;
            m2_8_reg <= n2_7_reg[NW-1] ? -n2_7_reg : n2_7_reg;
            md_8_reg <= dn7_reg[NW-1] ? -dn7_reg : dn7_reg;
        end
    end

    // ratio dividers; saturation flags ride alongside
    logic [F-1:0] q1;
    logic [F-1:0] q2;
    side_t        sd_reg [F];

    cpt_div #(.WIDTH(NW), .QBITS(F)) u_div1 (
        .clk (clk),
        .en  (en),
        .num (m1_8_reg),
        .den (md_8_reg),
        .quo (q1)
    );

    cpt_div #(.WIDTH(NW), .QBITS(F)) u_div2 (
        .clk (clk),
        .en  (en),
        .num (m2_8_reg),
        .den (md_8_reg),
        .quo (q2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0].rg <= rg8_reg;
            sd_reg[0].z1 <= z1_8_reg;
            sd_reg[0].z2 <= z2_8_reg;
            sd_reg[0].s1 <= m1_8_reg >= md_8_reg;
            sd_reg[0].s2 <= m2_8_reg >= md_8_reg;
            sd_reg[0].bl <= bl8_reg;
            for (int i = 1; i < F; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // blend stage 1: weights and edge products
    side_t          sd;
    logic [F:0]     r1;
    logic [F:0]     r2;
    logic [F:0]     t1;
    logic [F:0]     t2;
    logic [F+1:0]   tsum;
    logic [F:0]     wa_next;
    logic [F:0]     wb_next;
    logic [F:0]     wc_next;

    always_comb
    begin
        sd   = sd_reg[F-1];
        r1   = sd.z1 ? '0 : (sd.s1 ? WONE : {1'b0, q1});
        r2   = sd.z2 ? '0 : (sd.s2 ? WONE : {1'b0, q2});
        t1   = (sd.rg >= RGN_AB) ? r1 : '0;
        t2   = (sd.rg == RGN_IN) ? r2 : '0;
        tsum = (F+2)'(r1) + (F+2)'(r2);
        wa_next = '0;
        wb_next = '0;
        wc_next = '0;
        case (sd.rg)
            RGN_A:
            begin
                wa_next = WONE;
            end
            RGN_B:
            begin
                wb_next = WONE;
            end
            RGN_C:
            begin
                wc_next = WONE;
            end
            RGN_AB:
            begin
                wb_next = r1;
                wa_next = WONE - r1;
            end
            RGN_AC:
            begin
                wc_next = r1;
                wa_next = WONE - r1;
            end
            RGN_BC:
            begin
                wc_next = r1;
                wb_next = WONE - r1;
            end
            default:
            begin
                wb_next = r1;
                wc_next = r2;
                wa_next = (tsum >= (F+2)'(WONE)) ? '0 : (F+1)'((F+2)'(WONE) - tsum);
            end
        endcase
    end

    logic signed [PMW-1:0] pm1_reg [3];
    logic signed [PMW-1:0] pm2_reg [3];
    logic signed [W-1:0]   base_reg [3];
    region_t               rg_p1_reg;
    logic [F:0]            wa_p1_reg;
    logic [F:0]            wb_p1_reg;
    logic [F:0]            wc_p1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pm1_reg[k]  <= $signed({1'b0, t1}) * $signed(sd.bl.e1[k]);
                pm2_reg[k]  <= $signed({1'b0, t2}) * $signed(sd.bl.e2[k]);
                base_reg[k] <= sd.bl.base[k];
            end
            rg_p1_reg <= sd.rg;
            wa_p1_reg <= wa_next;
            wb_p1_reg <= wb_next;
            wc_p1_reg <= wc_next;
        end
    end

    // blend stage 2: exact sum with rounding offset
    logic signed [SW-1:0] sm_reg [3];
    region_t              rg_p2_reg;
    logic [F:0]           wa_p2_reg;
    logic [F:0]           wb_p2_reg;
    logic [F:0]           wc_p2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sm_reg[k] <= (SW'(base_reg[k]) <<< F) + SW'(pm1_reg[k]) + SW'(pm2_reg[k])
                           + HALF;
            end
            rg_p2_reg <= rg_p1_reg;
            wa_p2_reg <= wa_p1_reg;
            wb_p2_reg <= wb_p1_reg;
            wc_p2_reg <= wc_p1_reg;
        end
    end

    // blend stage 3: shift, saturate, output register
    logic [HW-1:0]       shv [3];
    logic signed [W-1:0] nr_next [3];
    logic signed [W-1:0] near_reg [3];
    region_t             rg_p3_reg;
    logic [F:0]          wa_p3_reg;
    logic [F:0]          wb_p3_reg;
    logic [F:0]          wc_p3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            shv[k] = sm_reg[k][SW-1:F];
            if ((&shv[k][HW-1:W-1]) || !(|shv[k][HW-1:W-1]))
                nr_next[k] = shv[k][W-1:0];
            else if (shv[k][HW-1])
                nr_next[k] = {1'b1, {(W-1){1'b0}}};
            else
                nr_next[k] = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                near_reg[k] <= nr_next[k];
            end
            rg_p3_reg <= rg_p2_reg;
            wa_p3_reg <= wa_p2_reg;
            wb_p3_reg <= wb_p2_reg;
            wc_p3_reg <= wc_p2_reg;
        end
    end

    assign near_x   = near_reg[0];
    assign near_y   = near_reg[1];
    assign near_z   = near_reg[2];
    assign weight_a = wa_p3_reg;
    assign weight_b = wb_p3_reg;
    assign weight_c = wc_p3_reg;
    assign region   = rg_p3_reg;

    a_vertex_a_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == RGN_A) |->
        (weight_a == WONE && weight_b == '0 && weight_c == '0))
        else $error("vertex A result with wrong weights");

    a_edge_ab_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == RGN_AB) |->
        (((F+2)'(weight_a) + (F+2)'(weight_b)) == (F+2)'(WONE) && weight_c == '0))
        else $error("edge AB weights do not sum to one");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weight_a <= WONE && weight_b <= WONE && weight_c <= WONE))
        else $error("weight above one");

endmodule

`default_nettype wire

[rtl/core/cpt_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module cpt_mul #(
    parameter int N = 52
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [N-1:0]   a,
    input  logic signed [N-1:0]   b,
    output logic signed [2*N-1:0] p
);
    localparam int L = N / 2;
    localparam int U = N - L;

    logic signed [U-1:0]   ah;
    logic signed [U-1:0]   bh;
    logic        [L-1:0]   al;
    logic        [L-1:0]   bl;
    logic signed [2*U-1:0] hh_reg;
    logic signed [U+L:0]   hl_reg;
    logic signed [U+L:0]   lh_reg;
    logic        [2*L-1:0] ll_reg;
    logic signed [2*N-1:0] p_reg;

    assign ah = a[N-1:L];
    assign al = a[L-1:0];
    assign bh = b[N-1:L];
    assign bl = b[L-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * $signed({1'b0, bl});
            lh_reg <= $signed({1'b0, al}) * bh;
            ll_reg <= al * bl;
            p_reg  <= ((2*N)'(hh_reg) <<< (2*L))
                    + (((2*N)'(hl_reg) + (2*N)'(lh_reg)) <<< L)
                    + $signed({{(2*N-2*L){1'b0}}, ll_reg});
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[rtl/core/cpt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, numerator below divisor.
`default_nettype none

module cpt_div #(
    parameter int WIDTH = 107,
    parameter int QBITS = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic [QBITS-1:0] quo
);
    logic [WIDTH-1:0] rem_reg [QBITS];
    logic [WIDTH-1:0] dvs_reg [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];

    for (genvar i = 0; i < QBITS; i++)
    begin : g_step
        logic [WIDTH-1:0] rem_in;
        logic [WIDTH-1:0] dvs_in;
        logic [QBITS-1:0] quo_in;
        logic [WIDTH:0]   rem_sh;
        logic             take;

        if (i == 0)
        begin : g_head
            assign rem_in = num;
            assign dvs_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_tail
            assign rem_in = rem_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign rem_sh = {rem_in, 1'b0};
        assign take   = rem_sh >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? WIDTH'(rem_sh - {1'b0, dvs_in}) : rem_sh[WIDTH-1:0];
                dvs_reg[i] <= dvs_in;
                quo_reg[i] <= {quo_in[QBITS-2:0], take};
            end
        end
    end

    assign quo = quo_reg[QBITS-1];

endmodule

`default_nettype wire
